### design/okrt_pkg.sv
package okrt_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths.
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 16;
  localparam int TOTAL_W = 22;
  localparam int HELD_W  = 7;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Request modes.
  typedef enum logic [2:0] {
    MODE_APPEND    = 3'd0,
    MODE_ORDERED   = 3'd1,
    MODE_DEL_FIRST = 3'd2,
    MODE_DEL_LAST  = 3'd3,
    MODE_FIND      = 3'd4,
    MODE_SUM       = 3'd5
  } mode_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_OPEN_RD,
    S_OPEN_WR,
    S_PUT,
    S_CLOSE_RD,
    S_CLOSE_WR,
    S_DONE
  } state_t;

endpackage

### design/ordered_key_record_table.sv
// Ordered key/value record table.
// Input channel (in_valid, in_stall, in_mode, in_key, in_value) carries one request:
// append, ordered insert, delete first/last match, find first match, or sum
// of the values of all matching records. Each request produces exactly one
// result on the output channel (out_valid, out_stall, out_status, out_found,
// out_found_value, out_total, out_entries_held).
// One request is processed at a time; in_stall stays high until the request
// has finished. Records live in a single-port table walked by one compare
// unit; each entry visited is read, then compared, and every shifted entry
// is read and then written back. A dropped insert or an unused mode goes
// straight to the result; an append writes at the end with no shift, an
// ordered insert scans to the first larger key and shifts the rest up, find
// stops at the first match, sum walks the whole table, and a delete shifts
// the later entries down to close the gap.
// The result sits in an output register; while out_stall is high it holds,
// and the block can still accept and work on the next request, waiting at
// its end until the register is free.
// Reset (rst_n low, synchronous) empties the table and drops any pending
// result; table contents are not cleared, only the record count.
module ordered_key_record_table
  import okrt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                in_mode,
  input  logic signed [KEY_W-1:0]   in_key,
  input  logic [VALUE_W-1:0]        in_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_status,
  output logic                      out_found,
  output logic [VALUE_W-1:0]        out_found_value,
  output logic [TOTAL_W-1:0]        out_total,
  output logic [HELD_W-1:0]         out_entries_held
);

  // Record storage.
  logic signed [KEY_W-1:0] key_mem   [TABLE_DEPTH];
  logic [VALUE_W-1:0]      value_mem [TABLE_DEPTH];

  state_t                  state_r, state_nxt;
  mode_t                   mode_r, mode_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic [VALUE_W-1:0]      val_r, val_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic [CNT_W-1:0]        pos_r, pos_nxt;
  logic                    hit_r, hit_nxt;
  status_t                 status_r, status_nxt;
  logic                    found_r, found_nxt;
  logic [VALUE_W-1:0]      fval_r, fval_nxt;
  logic [TOTAL_W-1:0]      acc_r, acc_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    load_out;
  logic [1:0]              out_status_r;
  logic                    out_found_r;
  logic [VALUE_W-1:0]      out_fval_r;
  logic [TOTAL_W-1:0]      out_total_r;
  logic [HELD_W-1:0]       out_held_r;

  // Table port signals.
  logic                    rd_en;
  logic [ADDR_W-1:0]       rd_addr;
  logic signed [KEY_W-1:0] rd_key_r;
  logic [VALUE_W-1:0]      rd_val_r;
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic signed [KEY_W-1:0] wr_key;
  logic [VALUE_W-1:0]      wr_val;

  logic [CNT_W-1:0]        idx_inc;
  logic [CNT_W-1:0]        idx_dec;
  logic [TOTAL_W:0]        acc_sum;
  logic                    accept;

  assign in_stall = (state_r != S_IDLE) || !rst_n;
  assign accept   = in_valid && !in_stall;
  assign idx_inc  = CNT_W'(idx_r + CNT_W'(1));
  assign idx_dec  = CNT_W'(idx_r - CNT_W'(1));
  assign acc_sum  = {1'b0, acc_r} + (TOTAL_W + 1)'(rd_val_r);

  // Single-port table: registered read, one write per cycle.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key_r <= key_mem[rd_addr];
      rd_val_r <= value_mem[rd_addr];
    end
    if (wr_en) begin
      key_mem[wr_addr]   <= wr_key;
      value_mem[wr_addr] <= wr_val;
    end
  end

  // Control and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers of the request in flight.
  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    key_r    <= key_nxt;
    val_r    <= val_nxt;
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    hit_r    <= hit_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    fval_r   <= fval_nxt;
    acc_r    <= acc_nxt;
    if (load_out) begin
      out_status_r <= status_r;
      out_found_r  <= found_r;
      out_fval_r   <= fval_r;
      out_total_r  <= acc_r;
      out_held_r   <= HELD_W'(count_r);
    end
  end

  // Sequencer: scan, gap shifting and result hand-off.
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    hit_nxt       = hit_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    fval_nxt      = fval_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    load_out      = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = idx_r[ADDR_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = idx_r[ADDR_W-1:0];
    wr_key        = rd_key_r;
    wr_val        = rd_val_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt   = mode_t'(in_mode);
          key_nxt    = in_key;
          val_nxt    = in_value;
          idx_nxt    = '0;
          pos_nxt    = count_r;
          hit_nxt    = 1'b0;
          status_nxt = ST_OK;
          found_nxt  = 1'b0;
          fval_nxt   = '0;
          acc_nxt    = '0;
          case (mode_t'(in_mode))
            MODE_APPEND: begin
              if (count_r >= CNT_W'(TABLE_DEPTH)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                idx_nxt   = count_r;
                state_nxt = S_OPEN_RD;
              end
            end
            MODE_ORDERED: begin
              if (count_r >= CNT_W'(TABLE_DEPTH)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_SCAN_RD;
              end
            end
            MODE_DEL_FIRST, MODE_DEL_LAST, MODE_FIND, MODE_SUM: begin
              state_nxt = S_SCAN_RD;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Issue a read of the next entry, or wrap up at the end of the table.
      S_SCAN_RD: begin
        if (idx_r < count_r) begin
          rd_en     = 1'b1;
          state_nxt = S_SCAN_CHK;
        end else begin
          case (mode_r)
            MODE_ORDERED: begin
              idx_nxt   = count_r;
              state_nxt = S_OPEN_RD;
            end
            MODE_DEL_FIRST, MODE_DEL_LAST: begin
              if (hit_r) begin
                idx_nxt   = pos_r;
                state_nxt = S_CLOSE_RD;
              end else begin
                status_nxt = ST_MISSING;
                state_nxt  = S_DONE;
              end
            end
            MODE_FIND: begin
              status_nxt = ST_MISSING;
              state_nxt  = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Compare the entry just read against the request key.
      S_SCAN_CHK: begin
        idx_nxt   = idx_inc;
        state_nxt = S_SCAN_RD;
        case (mode_r)
          MODE_ORDERED: begin
            if (rd_key_r > key_r) begin
              pos_nxt   = idx_r;
              idx_nxt   = count_r;
              state_nxt = S_OPEN_RD;
            end
          end
          MODE_DEL_FIRST: begin
            if (rd_key_r == key_r) begin
              hit_nxt   = 1'b1;
              found_nxt = 1'b1;
              pos_nxt   = idx_r;
              idx_nxt   = idx_r;
              state_nxt = S_CLOSE_RD;
            end
          end
          MODE_DEL_LAST: begin
            if (rd_key_r == key_r) begin
              hit_nxt   = 1'b1;
              found_nxt = 1'b1;
              pos_nxt   = idx_r;
            end
          end
          MODE_FIND: begin
            if (rd_key_r == key_r) begin
              found_nxt = 1'b1;
              fval_nxt  = rd_val_r;
              state_nxt = S_DONE;
            end
          end
          MODE_SUM: begin
            if (rd_key_r == key_r) begin
              acc_nxt = acc_sum[TOTAL_W] ? TOTAL_MAX : acc_sum[TOTAL_W-1:0];
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      // Open a gap at pos_r by moving entries up, from the top down.
      S_OPEN_RD: begin
        if (idx_r > pos_r) begin
          rd_en     = 1'b1;
          rd_addr   = idx_dec[ADDR_W-1:0];
          state_nxt = S_OPEN_WR;
        end else begin
          state_nxt = S_PUT;
        end
      end

      S_OPEN_WR: begin
        wr_en     = 1'b1;
        idx_nxt   = idx_dec;
        state_nxt = S_OPEN_RD;
      end

      S_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = pos_r[ADDR_W-1:0];
        wr_key    = key_r;
        wr_val    = val_r;
        count_nxt = CNT_W'(count_r + CNT_W'(1));
        state_nxt = S_DONE;
      end

      // Close the gap at pos_r by moving entries down, from the bottom up.
      S_CLOSE_RD: begin
        if (idx_inc < count_r) begin
          rd_en     = 1'b1;
          rd_addr   = idx_inc[ADDR_W-1:0];
          state_nxt = S_CLOSE_WR;
        end else begin
          count_nxt = CNT_W'(count_r - CNT_W'(1));
          state_nxt = S_DONE;
        end
      end

      S_CLOSE_WR: begin
        wr_en     = 1'b1;
        idx_nxt   = idx_inc;
        state_nxt = S_CLOSE_RD;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_found        = out_found_r;
  assign out_found_value  = out_fval_r;
  assign out_total        = out_total_r;
  assign out_entries_held = out_held_r;

endmodule

### design/okrt_checker.sv
module okrt_checker
  import okrt_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_status,
  input logic               out_found,
  input logic [VALUE_W-1:0] out_found_value,
  input logic [TOTAL_W-1:0] out_total,
  input logic [HELD_W-1:0]  out_entries_held
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_found) && $stable(out_found_value) && $stable(out_total) &&
      $stable(out_entries_held))
    else $error("stalled result changed");

  // Only one request is in flight: the input side closes after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous one still in progress");

  // A dropped insert only happens on a full table.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |->
      out_entries_held == HELD_W'(TABLE_DEPTH) && !out_found && out_total == '0)
    else $error("full status reported on a table that is not full");

  // A match is always reported with an ok status.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ST_OK)
    else $error("match reported with an error status");

  // A missing key leaves every data field clear.
  a_missing_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_MISSING |->
      !out_found && out_found_value == '0 && out_total == '0)
    else $error("missing key reported with data");

endmodule

bind ordered_key_record_table okrt_checker u_okrt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_found        (out_found),
  .out_found_value  (out_found_value),
  .out_total        (out_total),
  .out_entries_held (out_entries_held)
);
